// ===== rtl/core/sha256_pkg.sv =====
package sha256_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_POS     = 56;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned WORDS       = 8;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[r];
  endfunction

  // round control handed to the compression unit
  typedef struct packed {
    logic       start;
    logic       load;
    logic [3:0] load_idx;
    logic       round;
    logic [5:0] rnd;
    logic       fold;
  } cmp_ctrl_t;

endpackage

// ===== rtl/core/sha256_if.sv =====
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       has_byte;
  logic       is_last;
  modport source (output valid, message_byte, has_byte, is_last, input ready);
  modport sink   (input valid, message_byte, has_byte, is_last, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== rtl/core/sha256_compress.sv =====
module sha256_compress (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sha256_pkg::cmp_ctrl_t ctrl,
  input  logic [31:0]           load_word,
  input  logic                  iv_load,
  input  logic [2:0]            rd_idx,
  output logic [31:0]           rd_word
);
  import sha256_pkg::*;

  logic [31:0] h_r [WORDS];
  logic [31:0] v_r [WORDS];
  logic [31:0] w_r [16];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] wv, s0, s1, t1, t2;

  // one round of the shared datapath
  always_comb begin
    s0 = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    wv = (ctrl.rnd < 6'd16) ? w_r[0] : (s1 + w_r[9] + s0 + w_r[0]);
    t1 = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25)) +
         ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + round_k(ctrl.rnd) + wv;
    t2 = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22)) +
         ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  assign rd_word = h_r[rd_idx];

  // chaining words: IV on reset and after each digest
  always_ff @(posedge clk) begin
    if (!rst_n || iv_load) begin
      for (int i = 0; i < WORDS; i++) h_r[i] <= iv_word(3'(i));
    end else if (ctrl.fold) begin
      for (int i = 0; i < WORDS; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  // schedule window rotates; slot 0 holds the current word in the first 16 rounds, the word 16 back after
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      w_r[ctrl.load_idx] <= load_word;
    end else if (ctrl.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wv;
    end
    if (ctrl.start) begin
      for (int i = 0; i < WORDS; i++) v_r[i] <= h_r[i];
    end else if (ctrl.round) begin
      for (int i = 1; i < WORDS; i++) begin
        if (i != 4) v_r[i] <= v_r[i-1];
      end
      v_r[4] <= v_r[3] + t1;
      v_r[0] <= t1 + t2;
    end
  end

endmodule

// ===== rtl/core/sha256_stream_hasher_core.sv =====
// SHA-256 stream hasher, one shared round unit under a sequencer.
// A byte that does not fill a block is only stored; a full block runs
// the load, round and fold steps in that order.
// A last item adds a pad step and one or two blocks,
// then 8 output words, one per cycle while the sink is ready.
// Synchronous active-low reset: IV loaded, counters cleared, idle.
module sha256_stream_hasher_core (
  input logic clk,
  input logic rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  localparam int unsigned BLK_WORDS = BLOCK_BYTES / 4;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_OUT
  } state_t;

  state_t      state_r;
  logic [31:0] blk_r [BLK_WORDS];   // block bytes, big-endian in each word
  logic [31:0] pad_blk [BLK_WORDS];
  logic [6:0]  fill_r;
  logic [63:0] bits_r;
  logic        fin_r;    // finishing the message
  logic        lenblk_r; // current padded block carries the length
  logic [5:0]  cnt_r;
  logic [2:0]  oidx_r;
  cmp_ctrl_t   ctrl;
  logic [31:0] load_word, rd_word;
  logic        iv_load;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.digest_word = rd_word;
  assign out_ch.word_index = oidx_r;
  assign out_ch.last_word = (oidx_r == 3'd7);

  assign load_word = blk_r[cnt_r[3:0]];

  // padded block: 0x80 at the fill point, zeros after, length if it fits
  always_comb begin
    for (int w = 0; w < BLK_WORDS; w++) begin
      for (int b = 0; b < 4; b++) begin
        if (7'(4 * w + b) == fill_r) pad_blk[w][8*(3-b) +: 8] = PAD_BYTE;
        else if (7'(4 * w + b) > fill_r) pad_blk[w][8*(3-b) +: 8] = 8'h00;
        else pad_blk[w][8*(3-b) +: 8] = blk_r[w][8*(3-b) +: 8];
      end
    end
    if (fill_r < 7'(LEN_POS)) begin
      pad_blk[BLK_WORDS-2] = bits_r[63:32];
      pad_blk[BLK_WORDS-1] = bits_r[31:0];
    end
  end

  always_comb begin
    ctrl = '0;
    ctrl.start = (state_r == S_LOAD) && (cnt_r == 6'd0);
    ctrl.load = (state_r == S_LOAD);
    ctrl.load_idx = cnt_r[3:0];
    ctrl.round = (state_r == S_ROUND);
    ctrl.rnd = cnt_r;
    ctrl.fold = (state_r == S_FOLD);
  end
  assign iv_load = (state_r == S_OUT) && out_ch.ready && (oidx_r == 3'd7);

  sha256_compress u_cmp (
    .clk, .rst_n, .ctrl, .load_word, .iv_load, .rd_idx(oidx_r), .rd_word
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      fin_r <= 1'b0;
      lenblk_r <= 1'b0;
      cnt_r <= '0;
      oidx_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          fin_r <= in_ch.is_last;
          if (in_ch.has_byte) begin
            blk_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= in_ch.message_byte;
            bits_r <= bits_r + 64'd8;
            if (fill_r == 7'(BLOCK_BYTES - 1)) begin
              fill_r <= '0;
              cnt_r <= '0;
              state_r <= S_LOAD;
            end else begin
              fill_r <= fill_r + 7'd1;
              if (in_ch.is_last) state_r <= S_PAD;
            end
          end else if (in_ch.is_last) begin
            state_r <= S_PAD;
          end
        end
        // write the padded block
        S_PAD: begin
          for (int i = 0; i < BLK_WORDS; i++) blk_r[i] <= pad_blk[i];
          lenblk_r <= (fill_r < 7'(LEN_POS));
          cnt_r <= '0;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          cnt_r <= (cnt_r == 6'd15) ? 6'd0 : cnt_r + 6'd1;
          if (cnt_r == 6'd15) state_r <= S_ROUND;
        end
        S_ROUND: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(ROUNDS - 1)) state_r <= S_FOLD;
        end
        S_FOLD: begin
          if (!fin_r) begin
            state_r <= S_IDLE;
          end else if (lenblk_r) begin
            oidx_r <= '0;
            state_r <= S_OUT;
          end else if (fill_r == '0) begin
            // last byte filled the block: pad byte still to place
            state_r <= S_PAD;
          end else begin
            // second pad pass: only zeros and length
            fill_r <= '0;
            for (int i = 0; i < BLK_WORDS; i++) begin
              blk_r[i] <= (i == BLK_WORDS - 2) ? bits_r[63:32] :
                          (i == BLK_WORDS - 1) ? bits_r[31:0] : 32'h0;
            end
            lenblk_r <= 1'b1;
            cnt_r <= '0;
            state_r <= S_LOAD;
          end
        end
        S_OUT: if (out_ch.ready) begin
          oidx_r <= oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            fill_r <= '0;
            bits_r <= '0;
            fin_r <= 1'b0;
            lenblk_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> fin_r && lenblk_r) else $error("output without finish");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last_word) |=> (state_r == S_IDLE))
    else $error("no return to idle");
  a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOLD) |-> $past(state_r) == S_ROUND) else $error("fold early");
`endif

endmodule

// ===== sim/tb_sha256_stream_hasher_core.sv =====
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_core;
  import sha256_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  sha256_in_if  in_ch ();
  sha256_out_if out_ch ();

  sha256_stream_hasher_core u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  typedef struct packed {
    logic [7:0] message_byte;
    logic       has_byte;
    logic       is_last;
  } byte_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // hash state mirror
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [63:0] msg_bits;

  byte_word_t   pending_words [$];
  digest_word_t digest_q [$];
  int           fail_count = 0;
  bit           in_fire = 1'b0;  // input word taken at the last rising edge
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of blk into chain
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    for (int j = 16; j < 64; j++)
      w[j] = (rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10)) + w[j-7] +
             (rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3)) + w[j-16];
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] += v[j];
  endtask

  // absorb one accepted word; on the last mark pad and queue the digest
  task automatic absorb_word(byte_word_t it);
    digest_word_t d;
    if (it.has_byte) begin
      blk[fill] = it.message_byte;
      fill++;
      msg_bits += 64'd8;
      if (fill == BLOCK_BYTES) begin
        compress_block();
        fill = 0;
      end
    end
    if (it.is_last) begin
      blk[fill] = PAD_BYTE;
      fill++;
      if (fill > LEN_POS) begin
        while (fill < BLOCK_BYTES) blk[fill++] = 8'h00;
        compress_block();
        fill = 0;
      end
      while (fill < LEN_POS) blk[fill++] = 8'h00;
      for (int j = 0; j < 8; j++) blk[63-j] = msg_bits[8*j +: 8];
      compress_block();
      for (int j = 0; j < 8; j++) begin
        d.digest_word = chain[j];
        d.word_index  = 3'(j);
        d.last_word   = (j == 7);
        digest_q.push_back(d);
      end
      for (int j = 0; j < 8; j++) chain[j] = IV[j];
      fill = 0;
      msg_bits = '0;
    end
  endtask

  function automatic byte_word_t mk(logic [7:0] b, logic h, logic l);
    byte_word_t it;
    it.message_byte = b;
    it.has_byte     = h;
    it.is_last      = l;
    return it;
  endfunction

  // message of n random bytes, occasional idle or bare-finish ending
  task automatic push_message(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) pending_words.push_back(mk(8'($urandom), 1'b0, 1'b0));
      pending_words.push_back(mk(8'($urandom), 1'b1,
                              (i == n - 1) && $urandom_range(0, 1)));
    end
    if (n == 0 || !pending_words[$].is_last)
      pending_words.push_back(mk(8'($urandom), 1'b0, 1'b1));
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_fire) void'(pending_words.pop_front());
      if (!in_ch.valid || in_fire) begin
        if (pending_words.size() > 0 &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          {in_ch.message_byte, in_ch.has_byte, in_ch.is_last} <= pending_words[0];
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    digest_word_t exp_w;
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (in_fire)
      absorb_word(mk(in_ch.message_byte, in_ch.has_byte, in_ch.is_last));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h", out_ch.digest_word);
        fail_count++;
      end else begin
        exp_w = digest_q.pop_front();
        if (out_ch.digest_word !== exp_w.digest_word) begin
          $error("digest_word exp %h got %h", exp_w.digest_word, out_ch.digest_word);
          fail_count++;
        end
        if (out_ch.word_index !== exp_w.word_index) begin
          $error("word_index exp %0d got %0d", exp_w.word_index, out_ch.word_index);
          fail_count++;
        end
        if (out_ch.last_word !== exp_w.last_word) begin
          $error("last_word exp %0d got %0d", exp_w.last_word, out_ch.last_word);
          fail_count++;
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.message_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;
    for (int j = 0; j < 8; j++) chain[j] = IV[j];
    for (int j = 0; j < 64; j++) blk[j] = 8'h00;
    fill = 0;
    msg_bits = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: empty message, "abc", byte with last, idle, pad boundaries
    pending_words.push_back(mk(8'h00, 1'b0, 1'b1));
    pending_words.push_back(mk(8'h61, 1'b1, 1'b0));
    pending_words.push_back(mk(8'hff, 1'b0, 1'b0));
    pending_words.push_back(mk(8'h62, 1'b1, 1'b0));
    pending_words.push_back(mk(8'h63, 1'b1, 1'b1));
    pending_words.push_back(mk(8'hff, 1'b1, 1'b1));
    pending_words.push_back(mk(8'h00, 1'b1, 1'b0));
    pending_words.push_back(mk(8'h00, 1'b0, 1'b1));
    push_message(56);
    push_message(64);
    wait (pending_words.size() == 0 && digest_q.size() == 0);

    // random phases of sender idling and receiver stalls
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int m = 0; m < 3; m++)
        push_message($urandom_range(0, 12));
      wait (pending_words.size() == 0);
    end
    wait (digest_q.size() == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sha256_pkg.sv
rtl/core/sha256_if.sv
rtl/core/sha256_compress.sv
rtl/core/sha256_stream_hasher_core.sv
sim/tb_sha256_stream_hasher_core.sv
